// ----- hdl/tabx_pkg.sv -----
// ----------------------------------------------------------------------------
// tabx_pkg
// Types and constants shared by the tab expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tabx_pkg;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [6:0] MAX_TAB  = 7'd64;

   localparam int         CSR_ADDR_W    = 1;
   localparam int         CSR_DATA_W    = 8;
   localparam logic [0:0] REG_TAB_PITCH = 1'd0;
   localparam logic [0:0] REG_INDENT    = 1'd1;

   localparam logic [6:0] TAB_PITCH_RST = 7'd8;
   localparam logic [7:0] INDENT_RST    = 8'd0;

   typedef struct packed {
      logic [7:0] char_in;
      logic       start_of_text;
   } req_item_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_of_run;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- hdl/tab_expander.sv -----
// ----------------------------------------------------------------------------
// tab_expander
// Expands tab characters of a byte stream into spaces to the next tab stop.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per item plus a start-of-text flag that clears
//   the column first. rsp_* carries output bytes; last_of_run marks the final
//   byte caused by one request item. csr_* writes the tab stop pitch (index 0)
//   and indent_columns (index 1) and is to be used only while the block is idle;
//   the user keeps to this, since the block itself does not enforce it.
//   An ordinary byte, newline or carriage return shows up on rsp in the cycle
//   after it is taken; one such item per cycle is sustained unless rsp stalls.
//   A tab at or past the indent column runs a bit-serial remainder of
//   (column - indent) by the tab pitch on one shared subtract/compare unit,
//   then gives one space per cycle unless rsp stalls, 1 to 64 spaces.
//   A tab before the indent column gives one space, through the emit state.
//   req_ready is low while a tab is being worked on.
// Reset: column cleared, tab pitch 8, indent_columns 0, output empty.
// Stall: the output register holds while rsp_ready is low and stops new items.
// ----------------------------------------------------------------------------
`default_nettype none

module tab_expander
   import tabx_pkg::*;
#(
   parameter int COLUMN_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,

   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire req_item_type           req_item,

   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output rsp_item_type                rsp_item,

   input  wire                         csr_we,
   input  wire  [CSR_ADDR_W-1:0]       csr_addr,
   input  wire  [CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CNT_W = (COLUMN_BITS > 1) ? $clog2(COLUMN_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [6:0]             tab_pitch_ff;
   logic [7:0]             indent_ff;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [COLUMN_BITS-1:0] div_ff, div_in;
   logic [6:0]             rem_ff, rem_in;
   logic [CNT_W-1:0]       bit_ff, bit_in;
   logic [6:0]             cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   logic [6:0]             tw_eff;
   logic                   out_free;
   logic                   accept;
   logic [COLUMN_BITS-1:0] col_eff;
   logic [COLUMN_BITS-1:0] indent_ext;
   logic [6:0]             rem_shift;
   logic [6:0]             rem_next;
   logic [6:0]             spaces;
   logic [COLUMN_BITS-1:0] add_base;
   logic [6:0]             add_amt;
   logic [COLUMN_BITS:0]   add_sum;
   logic [COLUMN_BITS-1:0] add_sat;

   // Effective tab pitch: 0 acts as 1, above 64 acts as 64
   always_comb begin
      if (tab_pitch_ff == 7'd0) begin
         tw_eff = 7'd1;
      end else if (tab_pitch_ff > MAX_TAB) begin
         tw_eff = MAX_TAB;
      end else begin
         tw_eff = tab_pitch_ff;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign col_eff    = req_item.start_of_text ? '0 : column_ff;
   assign indent_ext = COLUMN_BITS'(indent_ff);

   // Shared remainder step
   assign rem_shift = {rem_ff[5:0], div_ff[COLUMN_BITS-1]};
   assign rem_next  = (rem_shift >= tw_eff) ? (rem_shift - tw_eff) : rem_shift;
   assign spaces    = tw_eff - rem_next;

   // Saturating column adder
   assign add_base = (state_ff == ST_IDLE) ? col_eff : column_ff;
   assign add_amt  = (state_ff == ST_IDLE) ? 7'd1 : spaces;
   assign add_sum  = {1'b0, add_base} + (COLUMN_BITS+1)'(add_amt);
   assign add_sat  = add_sum[COLUMN_BITS] ? '1 : add_sum[COLUMN_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      column_in    = column_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.char_in == CH_TAB) begin
                  if (col_eff >= indent_ext) begin
                     column_in = col_eff;
                     div_in    = col_eff - indent_ext;
                     rem_in    = 7'd0;
                     bit_in    = CNT_W'(COLUMN_BITS - 1);
                     state_in  = ST_DIV;
                  end else begin
                     column_in = add_sat;
                     cnt_in    = 7'd1;
                     state_in  = ST_EMIT;
                  end
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_item_in.char_out = req_item.char_in;
                  rsp_item_in.last_of_run = 1'b1;
                  if (req_item.char_in == CH_LF || req_item.char_in == CH_CR) begin
                     column_in = '0;
                  end else begin
                     column_in = add_sat;
                  end
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_next;
            div_in = {div_ff[COLUMN_BITS-2:0], 1'b0};
            bit_in = bit_ff - CNT_W'(1);
            if (bit_ff == '0) begin
               cnt_in    = spaces;
               column_in = add_sat;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.char_out    = CH_SPACE;
               rsp_item_in.last_of_run = (cnt_ff == 7'd1);
               cnt_in                  = cnt_ff - 7'd1;
               if (cnt_ff == 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         column_ff    <= '0;
         cnt_ff       <= 7'd0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         column_ff    <= column_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_pitch_ff <= TAB_PITCH_RST;
         indent_ff    <= INDENT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_TAB_PITCH: tab_pitch_ff <= csr_wdata[6:0];
            REG_INDENT:    indent_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff != 7'd0 && cnt_ff <= MAX_TAB))
      else $error("space count out of range");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < tw_eff))
      else $error("remainder not below tab pitch");

   a_plain_out: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.char_in != CH_TAB) |=>
         (rsp_valid_ff && rsp_item_ff.last_of_run && state_ff == ST_IDLE))
      else $error("plain item did not reach output");

   a_tab_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.char_in == CH_TAB) |=> !req_ready)
      else $error("ready during tab expansion");
`endif

endmodule

`default_nettype wire

// ----- tb/tab_expander_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tab_expander_tb
// Self-checking testbench for the tab expander.
// A scoreboard predicts every output byte from each accepted input item,
// tracking column, tab pitch and indent itself, and compares the bytes that
// come out in order. Directed items cover tab stops, tabs before the indent,
// line ends, the start flag and odd tab pitches. Random texts follow under
// several register settings. A short tab run crosses an indent at the widest
// pitch. Both sides stall at random, and there is one long output hold.
// ----------------------------------------------------------------------------

module tab_expander_tb;
   import tabx_pkg::*;

   localparam int          COL_BITS    = 16;
   localparam int unsigned COL_MAX     = (1 << COL_BITS) - 1;
   localparam int          STALL_LIMIT = 2000;
   localparam int          HOLD_CYCLES = 300;

   class expansion_scoreboard;
      logic [6:0]   tab_pitch;
      logic [7:0]   indent_cols;
      int unsigned  column;
      rsp_item_type expected_bytes[$];
      int           errors;

      function new();
         tab_pitch   = TAB_PITCH_RST;
         indent_cols = INDENT_RST;
         column      = 0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_TAB_PITCH)
            tab_pitch = val[6:0];
         else if (idx == REG_INDENT)
            indent_cols = val;
      endfunction

      function void note_char(req_item_type it);
         int unsigned width;
         int unsigned spaces;
         int unsigned col;
         col = it.start_of_text ? 0 : column;
         if (it.char_in == CH_TAB) begin
            width = tab_pitch;
            if (width == 0)
               width = 1;
            if (width > MAX_TAB)
               width = MAX_TAB;
            if (col >= indent_cols)
               spaces = width - ((col - indent_cols) % width);
            else
               spaces = 1;
            for (int unsigned k = 0; k < spaces; k++)
               expected_bytes.push_back(rsp_item_type'{CH_SPACE, k + 1 == spaces});
            col = col + spaces;
         end else begin
            expected_bytes.push_back(rsp_item_type'{it.char_in, 1'b1});
            if (it.char_in == CH_LF || it.char_in == CH_CR)
               col = 0;
            else
               col = col + 1;
         end
         column = (col > COL_MAX) ? COL_MAX : col;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 200)
            $display("mismatch: %s", msg);
      endtask

      task check_byte(rsp_item_type got);
         rsp_item_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %b", got.char_out, got.last_of_run));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.char_out !== want.char_out)
            report($sformatf("char_out %02h, want %02h", got.char_out, want.char_out));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
      endtask

      function int pending_count();
         return expected_bytes.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_item;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  quiet     = 1'b0;
   int                    hold_req  = 0;
   int unsigned           stuck_cycles = 0;

   expansion_scoreboard sb = new();

   tab_expander #(.COLUMN_BITS(COL_BITS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_char(req_item);
         if (rsp_valid && rsp_ready)
            sb.check_byte(rsp_item);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // output side: random stalls, or one long hold when asked
   initial begin : output_side
      int seen_hold;
      seen_hold = 0;
      forever begin
         @(posedge clock);
         if (hold_req != seen_hold) begin
            seen_hold = hold_req;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 18);
         end
      end
   end

   task automatic send_item(input logic [7:0] ch, input logic st);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 18) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item  <= req_item_type'{ch, st};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_mode(input logic [CSR_DATA_W-1:0] tw, input logic [CSR_DATA_W-1:0] ind);
      wait_drained();
      write_reg(REG_TAB_PITCH, tw);
      write_reg(REG_INDENT, ind);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char(int unsigned lf_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25)
         return CH_TAB;
      if (r < 25 + lf_pct)
         return ($urandom_range(0, 2) == 0) ? CH_CR : CH_LF;
      if (r < 85)
         return 8'($urandom_range(32, 126));
      return 8'($urandom_range(0, 255));
   endfunction

   // texts of random length; a few lack the start flag or carry a stray one
   task automatic send_texts(input int n, input int unsigned lf_pct);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         len = $urandom_range(3, 30);
         if (len > n - sent)
            len = n - sent;
         send_item(pick_char(lf_pct), $urandom_range(0, 9) != 0);
         for (int i = 1; i < len; i++)
            send_item(pick_char(lf_pct), $urandom_range(0, 49) == 0);
         sent += len;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_mode(TAB_PITCH_RST, INDENT_RST);

      send_item(8'h41, 1'b1);
      send_item(CH_TAB, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(CH_TAB, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_TAB, 1'b0);
      send_item(CH_CR, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(CH_TAB, 1'b1);

      // zero pitch acts as one
      set_mode(8'd0, 8'd0);
      send_item(CH_TAB, 1'b0);
      send_item(8'h62, 1'b0);

      // pitch above range, top data bit set
      set_mode(8'hFF, 8'd0);
      send_item(CH_TAB, 1'b1);
      send_item(CH_TAB, 1'b0);

      // tabs before and past the indent
      set_mode(8'd5, 8'd3);
      send_item(CH_TAB, 1'b1);
      send_item(8'h78, 1'b0);
      send_item(8'h79, 1'b0);
      send_item(CH_TAB, 1'b0);
      send_item(8'h7A, 1'b0);
      send_item(CH_TAB, 1'b0);

      set_mode(8'd1, 8'd0);
      send_texts(12, 8);
      wait_drained();
      send_texts(13, 8);

      set_mode(8'd64, 8'd0);
      hold_req <= hold_req + 1;
      send_texts(25, 8);

      set_mode(8'hC5, 8'd20);
      send_texts(20, 3);

      set_mode(8'd3, 8'd0);
      quiet = 1'b1;
      send_texts(25, 8);
      quiet = 1'b0;

      set_mode(8'($urandom_range(0, 70)), 8'($urandom_range(0, 30)));
      send_texts(20, 6);

      set_mode(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_texts(15, 2);

      // one-space tabs up to the indent, then full stops at the widest pitch
      set_mode(8'd64, 8'd4);
      send_item(CH_TAB, 1'b1);
      repeat (5) send_item(CH_TAB, 1'b0);
      send_item(8'h71, 1'b0);
      send_item(CH_TAB, 1'b0);
      set_mode(8'd10, 8'd7);
      send_item(CH_TAB, 1'b0);
      send_item(8'h71, 1'b0);
      send_item(CH_LF, 1'b0);
      send_item(CH_TAB, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending_count() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
